FILE: src/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types, constants and helpers for the row predicate filter.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int PatternBytes = 24;
  localparam int PatLenW      = 5;
  localparam int PosW         = 5;
  localparam int AccW         = 32;
  localparam int KeyW         = 10;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int InDataW      = 24;
  localparam int OutDataW     = 16;
  localparam int QDepth       = 2;
  localparam int QPtrW        = 1;

  typedef enum logic [2:0] {
    OP_LESS         = 3'd0,
    OP_EQUAL        = 3'd1,
    OP_GREATER      = 3'd2,
    OP_NOT_EQUAL    = 3'd3,
    OP_INCLUDES     = 3'd4,
    OP_NOT_INCLUDES = 3'd5,
    OP_ALL          = 3'd6,
    OP_UNKNOWN      = 3'd7
  } cmp_op_e;

  typedef enum logic [1:0] {
    COMB_REPLACE = 2'd0,
    COMB_AND     = 2'd1,
    COMB_OR      = 2'd2
  } comb_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPARE_OP     = 3'd0,
    CFG_NUMERIC_MODE   = 3'd1,
    CFG_COMBINE_MODE   = 3'd2,
    CFG_NUMBER_VALUE   = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4,
    CFG_PATTERN_WORD0  = 3'd5,
    CFG_PATTERN_WORD1  = 3'd6,
    CFG_PATTERN_WORD2  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } num_phase_e;

  // classified byte, front to back
  typedef struct packed {
    logic [PatternBytes-1:0] mask;
    logic                    present;
    logic                    last;
    logic                    is_digit;
    logic                    is_space;
    logic                    is_sign;
    logic                    is_minus;
    logic [3:0]              digit;
    logic [KeyW-1:0]         row_key;
    logic                    prior;
  } item_t;

  // finished cell, waiting for evaluation
  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic             neg;
    logic             eq;
    logic [PosW-1:0]  pos;
    logic             found;
    logic [KeyW-1:0]  row_key;
    logic             prior;
  } cell_t;

  typedef struct packed {
    cmp_op_e                op;
    logic                   numeric;
    logic [1:0]             comb;
    logic signed [AccW-1:0] number;
    logic [PatLenW-1:0]     plen;
  } eval_cfg_t;

  function automatic logic [PatLenW-1:0] clamp_len(input logic [PatLenW-1:0] len);
    logic [PatLenW-1:0] res;
    res = (len > PatLenW'(PatternBytes)) ? PatLenW'(PatternBytes) : len;
    return res;
  endfunction

endpackage

FILE: src/rpf_front.sv
// ----------------------------------------------------------------------------
// rpf_front
// Accepts cell bytes and classifies them: character class, digit value and
// the per-position pattern match mask.
// ----------------------------------------------------------------------------
module rpf_front import rpf_pkg::*; (
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [InDataW-1:0]        s_axis_tdata,  // cell_byte, row_key, prior_selected
  input  logic                      s_axis_tuser,  // byte_present
  input  logic                      s_axis_tlast,  // last_byte
  input  logic [PatternBytes*8-1:0] pattern_i,
  input  logic [PatLenW-1:0]        plen_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output item_t                     push_item_o
);

  logic [7:0] b;
  logic [PatternBytes-1:0] mask;

  assign b = s_axis_tdata[7:0];

  always_comb begin
    for (int i = 0; i < PatternBytes; i++) begin
      mask[i] = (PatLenW'(i) < plen_i) && (pattern_i[i*8 +: 8] == b);
    end
  end

  always_comb begin
    push_item_o          = '0;
    push_item_o.mask     = mask;
    push_item_o.present  = s_axis_tuser;
    push_item_o.last     = s_axis_tlast;
    push_item_o.is_digit = (b >= 8'h30) && (b <= 8'h39);
    push_item_o.is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    push_item_o.is_sign  = (b == 8'h2B) || (b == 8'h2D);
    push_item_o.is_minus = (b == 8'h2D);
    push_item_o.digit    = b[3:0];
    push_item_o.row_key  = s_axis_tdata[8 +: KeyW];
    push_item_o.prior    = s_axis_tdata[8 + KeyW];
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

FILE: src/rpf_fifo.sv
// ----------------------------------------------------------------------------
// rpf_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module rpf_fifo import rpf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t              entry_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]     count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/rpf_back.sv
// ----------------------------------------------------------------------------
// rpf_back
// Per-cell parse and match state, finished-cell register, evaluation and
// result register.
// ----------------------------------------------------------------------------
module rpf_back import rpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eval_cfg_t            cfg_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  item_t                item_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata   // out_row_key, predicate_true, now_selected
);

  // cell state
  logic [AccW-1:0]        acc_q, acc_d;
  num_phase_e             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   eq_q, eq_d;
  logic [PatternBytes-1:0] mv_q, mv_d;
  logic                   found_q, found_d;

  // finished cell and result
  logic                   fin_valid_q, fin_valid_d;
  cell_t                  fin_q, fin_d;
  logic                   out_valid_q, out_valid_d;
  logic [KeyW-1:0]        out_key_q;
  logic                   out_pred_q, out_sel_q;

  logic                   fin_adv, fin_free, pop;
  logic [PatLenW-1:0]     plen;
  logic [AccW+3:0]        acc_x10, limit;
  logic [AccW-1:0]        acc_next;
  logic                   byte_eq;
  logic [PatternBytes-1:0] mv_next;
  logic                   found_next;

  assign plen     = cfg_i.plen;
  assign fin_adv  = fin_valid_q && (!out_valid_q || m_axis_tready);
  assign fin_free = !fin_valid_q || fin_adv;
  assign pop      = item_valid_i && (!item_i.last || fin_free);
  assign item_ready_o = !item_i.last || fin_free;

  // saturating decimal accumulate
  always_comb begin
    acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (AccW+4)'(item_i.digit);
    limit   = neg_q ? (AccW+4)'(33'h0_8000_0000) : (AccW+4)'(33'h0_7FFF_FFFF);
    acc_next = (acc_x10 > limit) ? limit[AccW-1:0] : acc_x10[AccW-1:0];
  end

  // text compare and shift-and search
  always_comb begin
    byte_eq    = (pos_q < PosW'(PatternBytes)) && item_i.mask[pos_q];
    mv_next    = ({mv_q[PatternBytes-2:0], 1'b1}) & item_i.mask;
    found_next = (plen != '0) && mv_next[plen - 1'b1];
  end

  always_comb begin
    acc_d   = acc_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    pos_d   = pos_q;
    eq_d    = eq_q;
    mv_d    = mv_q;
    found_d = found_q;
    if (pop && item_i.present) begin
      case (phase_q)
        PH_SKIP: begin
          if (item_i.is_space) begin
            phase_d = PH_SKIP;
          end else if (item_i.is_sign) begin
            neg_d   = item_i.is_minus;
            phase_d = PH_DIGITS;
          end else if (item_i.is_digit) begin
            phase_d = PH_DIGITS;
            acc_d   = acc_next;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (item_i.is_digit) begin
            acc_d = acc_next;
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: phase_d = phase_q;
      endcase
      eq_d    = eq_q && byte_eq;
      pos_d   = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
      mv_d    = mv_next;
      found_d = found_q || found_next;
    end
  end

  // finished-cell register takes the updated state; cell state clears
  always_comb begin
    fin_valid_d = fin_valid_q;
    fin_d       = fin_q;
    if (fin_adv) begin
      fin_valid_d = 1'b0;
    end
    if (pop && item_i.last) begin
      fin_valid_d   = 1'b1;
      fin_d.acc     = acc_d;
      fin_d.neg     = neg_d;
      fin_d.eq      = eq_d;
      fin_d.pos     = pos_d;
      fin_d.found   = found_d;
      fin_d.row_key = item_i.row_key;
      fin_d.prior   = item_i.prior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      pos_q       <= '0;
      eq_q        <= 1'b1;
      mv_q        <= '0;
      found_q     <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
      if (pop && item_i.last) begin
        acc_q   <= '0;
        phase_q <= PH_SKIP;
        neg_q   <= 1'b0;
        pos_q   <= '0;
        eq_q    <= 1'b1;
        mv_q    <= '0;
        found_q <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        phase_q <= phase_d;
        neg_q   <= neg_d;
        pos_q   <= pos_d;
        eq_q    <= eq_d;
        mv_q    <= mv_d;
        found_q <= found_d;
      end
    end
  end

  // evaluation of the finished cell
  logic signed [AccW:0] num_val, num_ref;
  logic                 num_pred, txt_eq, txt_inc, txt_pred, pred, sel;

  always_comb begin
    num_val = fin_q.neg ? -$signed({1'b0, fin_q.acc}) : $signed({1'b0, fin_q.acc});
    num_ref = $signed({cfg_i.number[AccW-1], cfg_i.number});
    case (cfg_i.op)
      OP_LESS:    num_pred = (num_val < num_ref);
      OP_EQUAL:   num_pred = (num_val == num_ref);
      OP_GREATER: num_pred = (num_val > num_ref);
      default:    num_pred = 1'b1;
    endcase
    txt_eq  = fin_q.eq && (fin_q.pos == PosW'(plen));
    txt_inc = fin_q.found || (plen == '0);
    case (cfg_i.op)
      OP_EQUAL:        txt_pred = txt_eq;
      OP_NOT_EQUAL:    txt_pred = !txt_eq;
      OP_INCLUDES:     txt_pred = txt_inc;
      OP_NOT_INCLUDES: txt_pred = !txt_inc;
      OP_ALL:          txt_pred = 1'b1;
      default:         txt_pred = 1'b0;
    endcase
    pred = cfg_i.numeric ? num_pred : txt_pred;
    case (cfg_i.comb)
      COMB_AND: sel = pred & fin_q.prior;
      COMB_OR:  sel = pred | fin_q.prior;
      default:  sel = pred;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      fin_q <= fin_d;
    end
    if (fin_adv) begin
      out_key_q  <= fin_q.row_key;
      out_pred_q <= pred;
      out_sel_q  <= sel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_sel_q, out_pred_q, out_key_q});

`ifndef SYNTHESIS
  a_cell_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && item_i.last) |=> (pos_q == '0 && acc_q == '0 && phase_q == PH_SKIP && !found_q))
    else $error("cell state not cleared after last byte");

  a_acc_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!neg_q |-> acc_q <= AccW'(32'h7FFF_FFFF)) and (acc_q <= AccW'(32'h8000_0000)))
    else $error("accumulator beyond saturation limit");

  a_fresh_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (mv_q == '0 && eq_q && !found_q))
    else $error("match state set before any byte");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && !fin_adv) |=> (fin_valid_q && $stable(fin_q)))
    else $error("finished cell lost while stalled");
`endif

endmodule

FILE: src/row_predicate_filter_top.sv
// ----------------------------------------------------------------------------
// row_predicate_filter_top
// Streams cell bytes, parses or matches them, and emits one verdict per cell.
// ----------------------------------------------------------------------------
// Throughput: one cell byte per cycle unless the output stalls, back-to-back cells too.
// Path: the result for a cell passes, from the edge that accepts its last byte,
//   through the queue entry, then the finished-cell register, then the result
//   register, and waits there while the output is stalled.
// Reset: config registers return to compare_op all, others zero; cell state
//   cleared, queue and result register empty.
module row_predicate_filter_top import rpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // cell byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,  // [7:0] cell_byte, [17:8] row_key,
                                              // [18] prior_selected, rest zero
  input  logic                 s_axis_tuser,  // byte_present
  input  logic                 s_axis_tlast,  // last_byte
  // verdict stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata   // [9:0] out_row_key, [10] predicate_true,
                                              // [11] now_selected, rest zero
);

  // configuration registers
  cmp_op_e                 op_q;
  logic                    numeric_q;
  logic [1:0]              comb_q;
  logic signed [AccW-1:0]  number_q;
  logic [PatLenW-1:0]      plen_q;
  logic [CfgDataW-1:0]     word0_q, word1_q, word2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_ALL;
      numeric_q <= 1'b0;
      comb_q    <= COMB_REPLACE;
      number_q  <= '0;
      plen_q    <= '0;
      word0_q   <= '0;
      word1_q   <= '0;
      word2_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COMPARE_OP:     op_q      <= cmp_op_e'(cfg_data_i[2:0]);
        CFG_NUMERIC_MODE:   numeric_q <= cfg_data_i[0];
        CFG_COMBINE_MODE:   comb_q    <= cfg_data_i[1:0];
        CFG_NUMBER_VALUE:   number_q  <= $signed(cfg_data_i[AccW-1:0]);
        CFG_PATTERN_LENGTH: plen_q    <= cfg_data_i[PatLenW-1:0];
        CFG_PATTERN_WORD0:  word0_q   <= cfg_data_i;
        CFG_PATTERN_WORD1:  word1_q   <= cfg_data_i;
        CFG_PATTERN_WORD2:  word2_q   <= cfg_data_i;
        default:            op_q      <= op_q;
      endcase
    end
  end

  // pattern bytes, byte 0 lowest; length clamped to the pattern size
  logic [PatternBytes*8-1:0] pattern;
  logic [PatLenW-1:0]        plen_eff;
  eval_cfg_t                 eval_cfg;

  assign pattern  = (PatternBytes*8)'({word2_q, word1_q, word0_q});
  assign plen_eff = clamp_len(plen_q);

  always_comb begin
    eval_cfg.op      = op_q;
    eval_cfg.numeric = numeric_q;
    eval_cfg.comb    = comb_q;
    eval_cfg.number  = number_q;
    eval_cfg.plen    = plen_eff;
  end

  // front: classify each byte and compute its pattern match mask
  logic  push_valid, push_ready;
  item_t push_item;

  rpf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .pattern_i     (pattern),
    .plen_i        (plen_eff),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // short queue decouples acceptance from cell processing
  logic  pop_valid, pop_ready;
  item_t pop_item;

  rpf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // back: per-cell parse/match state, evaluation and result register
  rpf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (eval_cfg),
    .item_valid_i  (pop_valid),
    .item_ready_o  (pop_ready),
    .item_i        (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
